[rtl/core/rgmi_pkg.sv]
// Shared types, command codes and constants of the multilinear grid interpolator.
`timescale 1ns / 1ps

package rgmi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [2:0] CFG_DIMS  = 3'd0;
    localparam logic [2:0] CFG_SIZE0 = 3'd1;
    localparam logic [2:0] CFG_SIZE1 = 3'd2;
    localparam logic [2:0] CFG_SIZE2 = 3'd3;
    localparam logic [2:0] CFG_SIZE3 = 3'd4;

    localparam logic [1:0] CMD_LOAD_COORD = 2'd0;
    localparam logic [1:0] CMD_LOAD_VALUE = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;

    // The quotient of one interpolation step is clipped to this power of two.
    localparam int Q_CAP_BIT = 40;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         axis_sel;
        logic [11:0]        entry_index;
        logic signed [31:0] load_data;
        logic signed [31:0] pos0;
        logic signed [31:0] pos1;
        logic signed [31:0] pos2;
        logic signed [31:0] pos3;
    } rgmi_in_t;

    typedef struct packed {
        logic               inside_res;
        logic signed [31:0] interp_value;
    } rgmi_out_t;

    typedef enum logic [4:0] {
        OP_NONE      = 5'd0,
        OP_ACCEPT    = 5'd1,
        OP_RD_LO     = 5'd2,
        OP_RD_HI     = 5'd3,
        OP_RD_MID    = 5'd4,
        OP_CMP       = 5'd5,
        OP_AXIS_DONE = 5'd6,
        OP_STRIDE    = 5'd7,
        OP_CADDR     = 5'd8,
        OP_GVAL      = 5'd9,
        OP_PUSH      = 5'd10,
        OP_LA        = 5'd11,
        OP_LB        = 5'd12,
        OP_LC        = 5'd13,
        OP_LDONE     = 5'd14,
        OP_HIT       = 5'd15,
        OP_MISS      = 5'd16
    } rgmi_op_t;

    typedef struct packed {
        logic x_lt;
        logic x_gt;
        logic narrow;
        logic ax_last;
        logic lvl_last;
        logic cbit;
        logic lerp_done;
        logic out_free;
    } rgmi_status_t;

endpackage

[rtl/core/rgmi_lerp.sv]
// One linear interpolation step: exact product and a restoring divider, one bit per cycle.
`timescale 1ns / 1ps

module rgmi_lerp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] v1,
    input  logic signed [31:0] v2,
    input  logic signed [31:0] p,
    input  logic signed [31:0] xa,
    input  logic signed [31:0] xb,
    output logic               done,
    output logic signed [31:0] result
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_FIN  = 4'b1000
    } lerp_state_t;

    localparam logic [65:0] QCAP = 66'd1 << rgmi_pkg::Q_CAP_BIT;

    lerp_state_t        state_reg;
    logic               done_reg;
    logic signed [31:0] result_reg;
    logic signed [31:0] v1_reg;
    logic               neg_reg;
    logic               triv_reg;
    logic [32:0]        ad_reg;
    logic [32:0]        at_reg;
    logic [32:0]        aden_reg;
    logic [65:0]        prod_reg;
    logic [32:0]        rem_reg;
    logic [6:0]         cnt_reg;

    logic signed [32:0] d_c;
    logic signed [32:0] t_c;
    logic signed [32:0] den_c;
    logic [33:0]        r_sh;
    logic               q_bit;
    logic [33:0]        r_sub;
    logic [40:0]        q_cap;
    logic signed [42:0] sum_c;
    logic signed [31:0] sat_c;

    assign d_c   = 33'(v2) - 33'(v1);
    assign t_c   = 33'(p) - 33'(xa);
    assign den_c = 33'(xb) - 33'(xa);

    assign r_sh  = {rem_reg, prod_reg[65]};
    assign q_bit = (r_sh >= {1'b0, aden_reg});
    assign r_sub = r_sh - {1'b0, aden_reg};

    always_comb begin
        q_cap = (prod_reg > QCAP) ? QCAP[40:0] : prod_reg[40:0];
        if (neg_reg) begin
            sum_c = 43'(v1_reg) - $signed({2'b00, q_cap});
        end else begin
            sum_c = 43'(v1_reg) + $signed({2'b00, q_cap});
        end
        if (sum_c > 43'sd2147483647) begin
            sat_c = 32'sh7FFFFFFF;
        end else if (sum_c < -43'sd2147483648) begin
            sat_c = 32'sh80000000;
        end else begin
            sat_c = sum_c[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        v1_reg   <= v1;
                        triv_reg <= (den_c == '0) || (d_c == '0) || (t_c == '0);
                        neg_reg  <= d_c[32] ^ (t_c[32] ^ den_c[32]);
                        ad_reg   <= d_c[32] ? 33'(-d_c) : 33'(d_c);
                        at_reg   <= t_c[32] ? 33'(-t_c) : 33'(t_c);
                        aden_reg <= den_c[32] ? 33'(-den_c) : 33'(den_c);
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (triv_reg) begin
                        result_reg <= v1_reg;
                        done_reg   <= 1'b1;
                        state_reg  <= L_IDLE;
                    end else begin
                        prod_reg  <= 66'(ad_reg) * 66'(at_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= 7'd65;
                        state_reg <= L_DIV;
                    end
                end
                L_DIV: begin
                    rem_reg  <= q_bit ? r_sub[32:0] : r_sh[32:0];
                    prod_reg <= {prod_reg[64:0], q_bit};
                    cnt_reg  <= cnt_reg - 7'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN: begin
                    result_reg <= sat_c;
                    done_reg   <= 1'b1;
                    state_reg  <= L_IDLE;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/rgmi_dpath.sv]
// Datapath: configuration, coordinate and value memories, search, addressing and output register.
`timescale 1ns / 1ps

module rgmi_dpath #(
    parameter int MAX_DIMS    = 4,
    parameter int AXIS_POINTS = 16,
    parameter int VALUE_DEPTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rgmi_pkg::rgmi_op_t                  op,
    output rgmi_pkg::rgmi_status_t              status,
    input  rgmi_pkg::rgmi_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rgmi_pkg::rgmi_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rgmi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgmi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W    = $clog2(AXIS_POINTS);
    localparam int SZ_W     = IDX_W + 1;
    localparam int AX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ND_W     = $clog2(MAX_DIMS + 1);
    localparam int CA_DEPTH = MAX_DIMS * AXIS_POINTS;
    localparam int CA_W     = $clog2(CA_DEPTH);
    localparam int GA_W     = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int FL_W     = MAX_DIMS * IDX_W + 1;

    logic [2:0]               dims_reg;
    logic [4:0]               size_reg [4];

    logic [ND_W-1:0]          nd;
    logic [AX_W-1:0]          nd_m1;
    logic [SZ_W-1:0]          size_eff [MAX_DIMS];

    logic signed [31:0]       coord_mem [CA_DEPTH];
    logic signed [31:0]       grid_mem [VALUE_DEPTH];
    logic signed [31:0]       c_rd_reg;
    logic signed [31:0]       g_rd_reg;

    logic [AX_W-1:0]          ax_reg;
    logic [AX_W-1:0]          k_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         iv_reg [MAX_DIMS];
    logic signed [31:0]       pos_reg [MAX_DIMS];
    logic [FL_W-1:0]          stride_reg [MAX_DIMS];
    logic [FL_W-1:0]          acc_reg;
    logic [FL_W-1:0]          base_reg;
    logic [FL_W-1:0]          flat_reg;
    logic                     inr_reg;
    logic [MAX_DIMS-1:0]      c_reg;
    logic signed [31:0]       pend_reg [MAX_DIMS];
    logic signed [31:0]       val_reg;
    logic signed [31:0]       xa_reg;
    logic                     m_valid_reg;
    rgmi_pkg::rgmi_out_t      m_data_reg;

    logic signed [31:0]       pos_in [4];
    logic [IDX_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         cur_iv;
    logic [IDX_W-1:0]         rd_j;
    logic [CA_W-1:0]          ca;
    logic [CA_W-1:0]          wa;
    logic                     wr_c;
    logic                     wr_g;
    logic [FL_W-1:0]          offset;
    logic [FL_W-1:0]          flat_c;
    logic signed [31:0]       x_cur;
    logic                     lerp_done;
    logic signed [31:0]       lerp_res;

    assign pos_in[0] = s_data.pos0;
    assign pos_in[1] = s_data.pos1;
    assign pos_in[2] = s_data.pos2;
    assign pos_in[3] = s_data.pos3;

    always_comb begin
        if (dims_reg == '0) begin
            nd = ND_W'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            nd = ND_W'(MAX_DIMS);
        end else begin
            nd = ND_W'(dims_reg);
        end
        nd_m1 = AX_W'(nd - ND_W'(1));
    end

    always_comb begin
        for (int a = 0; a < MAX_DIMS; a++) begin
            if (a < 4) begin
                if (size_reg[2'(a)] < 5'd2) begin
                    size_eff[a] = SZ_W'(2);
                end else if (int'(size_reg[2'(a)]) > AXIS_POINTS) begin
                    size_eff[a] = SZ_W'(AXIS_POINTS);
                end else begin
                    size_eff[a] = SZ_W'(size_reg[2'(a)]);
                end
            end else begin
                size_eff[a] = SZ_W'(2);
            end
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign cur_iv  = iv_reg[ax_reg];
    assign x_cur   = pos_reg[ax_reg];

    always_comb begin
        case (op)
            rgmi_pkg::OP_RD_HI:  rd_j = hi_reg;
            rgmi_pkg::OP_RD_MID: rd_j = mid;
            rgmi_pkg::OP_LA:     rd_j = cur_iv;
            rgmi_pkg::OP_LB:     rd_j = cur_iv + IDX_W'(1);
            default:             rd_j = '0;
        endcase
    end

    assign ca   = CA_W'(int'(ax_reg) * AXIS_POINTS + int'(rd_j));
    assign wa   = CA_W'(int'(s_data.axis_sel) * AXIS_POINTS + int'(s_data.entry_index));
    assign wr_c = (op == rgmi_pkg::OP_ACCEPT) && (s_data.cmd == rgmi_pkg::CMD_LOAD_COORD)
                  && (int'(s_data.axis_sel) < MAX_DIMS)
                  && (int'(s_data.entry_index) < AXIS_POINTS);
    assign wr_g = (op == rgmi_pkg::OP_ACCEPT) && (s_data.cmd == rgmi_pkg::CMD_LOAD_VALUE)
                  && (int'(s_data.entry_index) < VALUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_c) begin
            coord_mem[wa] <= s_data.load_data;
        end
        c_rd_reg <= coord_mem[ca];
    end

    always_ff @(posedge aclk) begin
        if (wr_g) begin
            grid_mem[GA_W'(s_data.entry_index)] <= s_data.load_data;
        end
        g_rd_reg <= grid_mem[GA_W'(flat_reg)];
    end

    always_comb begin
        offset = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if ((k < int'(nd)) && c_reg[k]) begin
                offset = offset + stride_reg[k];
            end
        end
        flat_c = base_reg + offset;
    end

    rgmi_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (op == rgmi_pkg::OP_LC),
        .v1      (pend_reg[k_reg]),
        .v2      (val_reg),
        .p       (x_cur),
        .xa      (xa_reg),
        .xb      (c_rd_reg),
        .done    (lerp_done),
        .result  (lerp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= 3'd1;
            for (int i = 0; i < 4; i++) begin
                size_reg[i] <= 5'd2;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rgmi_pkg::CFG_DIMS:  dims_reg    <= cfg_wdata[2:0];
                rgmi_pkg::CFG_SIZE0: size_reg[0] <= cfg_wdata;
                rgmi_pkg::CFG_SIZE1: size_reg[1] <= cfg_wdata;
                rgmi_pkg::CFG_SIZE2: size_reg[2] <= cfg_wdata;
                rgmi_pkg::CFG_SIZE3: size_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            rgmi_pkg::OP_ACCEPT: begin
                for (int a = 0; a < MAX_DIMS; a++) begin
                    pos_reg[a] <= (a < 4) ? pos_in[2'(a)] : 32'sd0;
                end
                ax_reg <= '0;
            end
            rgmi_pkg::OP_RD_LO: begin
                lo_reg <= '0;
                hi_reg <= IDX_W'(size_eff[ax_reg] - SZ_W'(1));
            end
            rgmi_pkg::OP_CMP: begin
                if (x_cur > c_rd_reg) begin
                    lo_reg <= mid;
                end else begin
                    hi_reg <= mid;
                end
            end
            rgmi_pkg::OP_AXIS_DONE: begin
                iv_reg[ax_reg] <= lo_reg;
                if (ax_reg == nd_m1) begin
                    k_reg    <= '0;
                    acc_reg  <= FL_W'(1);
                    base_reg <= '0;
                end else begin
                    ax_reg <= ax_reg + AX_W'(1);
                end
            end
            rgmi_pkg::OP_STRIDE: begin
                stride_reg[k_reg] <= acc_reg;
                base_reg <= base_reg + FL_W'(acc_reg * FL_W'(cur_iv));
                acc_reg  <= FL_W'(acc_reg * FL_W'(size_eff[ax_reg]));
                k_reg    <= k_reg + AX_W'(1);
                ax_reg   <= ax_reg - AX_W'(1);
                c_reg    <= '0;
            end
            rgmi_pkg::OP_CADDR: begin
                flat_reg <= flat_c;
                inr_reg  <= (64'(flat_c) < 64'(VALUE_DEPTH));
                k_reg    <= '0;
                ax_reg   <= nd_m1;
            end
            rgmi_pkg::OP_GVAL: begin
                val_reg <= inr_reg ? g_rd_reg : 32'sd0;
            end
            rgmi_pkg::OP_PUSH: begin
                pend_reg[k_reg] <= val_reg;
                c_reg <= c_reg + MAX_DIMS'(1);
            end
            rgmi_pkg::OP_LB: begin
                xa_reg <= c_rd_reg;
            end
            rgmi_pkg::OP_LDONE: begin
                val_reg <= lerp_res;
                k_reg   <= k_reg + AX_W'(1);
                ax_reg  <= ax_reg - AX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((op == rgmi_pkg::OP_HIT) || (op == rgmi_pkg::OP_MISS)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == rgmi_pkg::OP_HIT) begin
            m_data_reg.inside_res   <= 1'b1;
            m_data_reg.interp_value <= val_reg;
        end else if (op == rgmi_pkg::OP_MISS) begin
            m_data_reg.inside_res   <= 1'b0;
            m_data_reg.interp_value <= 32'sd0;
        end
    end

    assign status.x_lt      = x_cur < c_rd_reg;
    assign status.x_gt      = x_cur > c_rd_reg;
    assign status.narrow    = ({1'b0, hi_reg} <= ({1'b0, lo_reg} + (IDX_W + 1)'(1)));
    assign status.ax_last   = (ax_reg == nd_m1);
    assign status.lvl_last  = (k_reg == nd_m1);
    assign status.cbit      = c_reg[k_reg];
    assign status.lerp_done = lerp_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/rgmi_ctrl.sv]
// Controller: sequences the search, the corner walk and the interpolation steps.
`timescale 1ns / 1ps

module rgmi_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic [1:0]              s_cmd,
    output logic                    s_ready,
    input  rgmi_pkg::rgmi_status_t  status,
    output rgmi_pkg::rgmi_op_t      op
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_RDLO   = 16'h0002,
        S_RDHI   = 16'h0004,
        S_CHKHI  = 16'h0008,
        S_LOOP   = 16'h0010,
        S_CMP    = 16'h0020,
        S_STRIDE = 16'h0040,
        S_CADDR  = 16'h0080,
        S_GRD    = 16'h0100,
        S_GVAL   = 16'h0200,
        S_CARRY  = 16'h0400,
        S_LB     = 16'h0800,
        S_LC     = 16'h1000,
        S_LWAIT  = 16'h2000,
        S_HIT    = 16'h4000,
        S_MISS   = 16'h8000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb begin
        state_next = state_reg;
        op         = rgmi_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op = rgmi_pkg::OP_ACCEPT;
                    if (s_cmd == rgmi_pkg::CMD_QUERY) begin
                        state_next = S_RDLO;
                    end
                end
            end
            S_RDLO: begin
                op         = rgmi_pkg::OP_RD_LO;
                state_next = S_RDHI;
            end
            S_RDHI: begin
                op         = rgmi_pkg::OP_RD_HI;
                state_next = status.x_lt ? S_MISS : S_CHKHI;
            end
            S_CHKHI: begin
                state_next = status.x_gt ? S_MISS : S_LOOP;
            end
            S_LOOP: begin
                if (status.narrow) begin
                    op         = rgmi_pkg::OP_AXIS_DONE;
                    state_next = status.ax_last ? S_STRIDE : S_RDLO;
                end else begin
                    op         = rgmi_pkg::OP_RD_MID;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                op         = rgmi_pkg::OP_CMP;
                state_next = S_LOOP;
            end
            S_STRIDE: begin
                op = rgmi_pkg::OP_STRIDE;
                if (status.lvl_last) begin
                    state_next = S_CADDR;
                end
            end
            S_CADDR: begin
                op         = rgmi_pkg::OP_CADDR;
                state_next = S_GRD;
            end
            S_GRD: begin
                state_next = S_GVAL;
            end
            S_GVAL: begin
                op         = rgmi_pkg::OP_GVAL;
                state_next = S_CARRY;
            end
            S_CARRY: begin
                if (status.cbit) begin
                    op         = rgmi_pkg::OP_LA;
                    state_next = S_LB;
                end else begin
                    op         = rgmi_pkg::OP_PUSH;
                    state_next = S_CADDR;
                end
            end
            S_LB: begin
                op         = rgmi_pkg::OP_LB;
                state_next = S_LC;
            end
            S_LC: begin
                op         = rgmi_pkg::OP_LC;
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                if (status.lerp_done) begin
                    op         = rgmi_pkg::OP_LDONE;
                    state_next = status.lvl_last ? S_HIT : S_CARRY;
                end
            end
            S_HIT: begin
                if (status.out_free) begin
                    op         = rgmi_pkg::OP_HIT;
                    state_next = S_IDLE;
                end
            end
            S_MISS: begin
                if (status.out_free) begin
                    op         = rgmi_pkg::OP_MISS;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

[rtl/core/rectilinear_grid_multilinear_interp.sv]
// Top level of the multilinear interpolator on a rectilinear grid.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   rgmi_in_t: command, load entry, query point
// m_        out        m_valid / m_ready   rgmi_out_t: inside flag, Q16.16 value
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// A load or an unused command leaves the input ready for the next transfer. A query
// runs a binary search per axis, reads the grid corners in turn and runs each
// interpolation step through the shared divider that yields one quotient bit per cycle.
// The next transfer is taken once the result sits in the output register, even while
// it waits for m_ready. Reset is synchronous and active low; the memories are not
// cleared.
`timescale 1ns / 1ps

module rectilinear_grid_multilinear_interp #(
    parameter int MAX_DIMS    = 4,
    parameter int AXIS_POINTS = 16,
    parameter int VALUE_DEPTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rgmi_pkg::rgmi_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rgmi_pkg::rgmi_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rgmi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgmi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rgmi_pkg::rgmi_op_t     op;
    rgmi_pkg::rgmi_status_t status;

    rgmi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    rgmi_dpath #(
        .MAX_DIMS    (MAX_DIMS),
        .AXIS_POINTS (AXIS_POINTS),
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .status    (status),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.cmd == rgmi_pkg::CMD_QUERY)) |=> !s_ready)
        else $error("input still ready after a query transfer");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.cmd != rgmi_pkg::CMD_QUERY) && !m_valid)
        |=> !m_valid)
        else $error("result produced by a load or unused command");

    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while a query is still in progress");
`endif

endmodule
